// File: rtl/pdrb_pkg.sv
// pdrb_pkg: types, constants and helper functions of the pose estimator
// used by every rtl file of the block; depends on nothing
`default_nettype none
package pdrb_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned HEAD_W = 20;
  localparam int unsigned REF_HEAD_W = 19;
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned CORD_W = 32;
  localparam int unsigned ANG_W  = 34;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W = 65;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned CNT_W = 5;

  localparam logic [IDX_W-1:0] REG_BLEND_GAIN  = 8'd0;
  localparam logic [IDX_W-1:0] REG_TICK_PERIOD = 8'd1;
  localparam logic [CFG_W-1:0] BLEND_GAIN_RST  = 16'd1311;
  localparam logic [CFG_W-1:0] TICK_PERIOD_RST = 16'd655;

  localparam logic signed [HEAD_W:0] PI_Q     = 21'sd205887;
  localparam logic signed [HEAD_W:0] TWO_PI_Q = 21'sd411774;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CORD_W-1:0] CORDIC_START = 32'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BLEND_X, ST_BLEND_Y, ST_DIST, ST_INC, ST_ROTATE,
    ST_MOVE_X, ST_MOVE_Y, ST_FINISH, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_BX, MUL_BY, MUL_LIN, MUL_ANG, MUL_CX, MUL_SY
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load;
    logic     prod_en;
    mul_sel_t mul_sel;
    logic     rnd30;
    logic     upd_x;
    logic     upd_y;
    logic     wrap_h;
    logic     dist_en;
    logic     inc_en;
    logic     cordic_start;
    logic     cordic_step;
    logic     final_h;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic last_iter;
  } status_t;

  function automatic logic [HEAD_W-1:0] wrap_heading(input logic signed [HEAD_W:0] h);
    logic signed [HEAD_W:0] v;
    v = h;
    if (v < -PI_Q) v = v + TWO_PI_Q;
    if (v > PI_Q) v = v - TWO_PI_Q;
    return v[HEAD_W-1:0];
  endfunction

  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic [POS_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'h8000_0000;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pdrb_if.sv
// pdrb interfaces: item, result and configuration channels
// depends on pdrb_pkg for widths
`default_nettype none
interface pdrb_item_if;
  logic valid;
  logic ready;
  logic op;
  logic signed [pdrb_pkg::POS_W-1:0] ref_x;
  logic signed [pdrb_pkg::POS_W-1:0] ref_y;
  logic signed [pdrb_pkg::REF_HEAD_W-1:0] ref_heading;
  logic signed [pdrb_pkg::SPEED_W-1:0] lin_speed;
  logic signed [pdrb_pkg::SPEED_W-1:0] ang_speed;
  modport source (output valid, op, ref_x, ref_y, ref_heading, lin_speed, ang_speed,
                  input ready);
  modport sink (input valid, op, ref_x, ref_y, ref_heading, lin_speed, ang_speed,
                output ready);
endinterface

interface pdrb_result_if;
  logic valid;
  logic ready;
  logic signed [pdrb_pkg::POS_W-1:0] est_x_out;
  logic signed [pdrb_pkg::POS_W-1:0] est_y_out;
  logic signed [pdrb_pkg::REF_HEAD_W-1:0] est_heading_out;
  modport source (output valid, est_x_out, est_y_out, est_heading_out, input ready);
  modport sink (input valid, est_x_out, est_y_out, est_heading_out, output ready);
endinterface

interface pdrb_cfg_if;
  logic valid;
  logic ready;
  logic [pdrb_pkg::IDX_W-1:0] index;
  logic [pdrb_pkg::CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/pdrb_ctrl.sv
// pdrb_ctrl: sequencing state machine and result valid flag
// depends on pdrb_pkg
`default_nettype none
module pdrb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic             item_op,
  output logic                  item_ready,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire pdrb_pkg::status_t status,
  output pdrb_pkg::cmd_t        cmd
);

  pdrb_pkg::state_t state, state_next;
  logic out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdrb_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pdrb_pkg::ST_IDLE: begin
        if (item_valid) state_next = item_op ? pdrb_pkg::ST_BLEND_X : pdrb_pkg::ST_DONE;
      end
      pdrb_pkg::ST_BLEND_X: state_next = pdrb_pkg::ST_BLEND_Y;
      pdrb_pkg::ST_BLEND_Y: state_next = pdrb_pkg::ST_DIST;
      pdrb_pkg::ST_DIST:    state_next = pdrb_pkg::ST_INC;
      pdrb_pkg::ST_INC:     state_next = pdrb_pkg::ST_ROTATE;
      pdrb_pkg::ST_ROTATE: begin
        if (status.last_iter) state_next = pdrb_pkg::ST_MOVE_X;
      end
      pdrb_pkg::ST_MOVE_X:  state_next = pdrb_pkg::ST_MOVE_Y;
      pdrb_pkg::ST_MOVE_Y:  state_next = pdrb_pkg::ST_FINISH;
      pdrb_pkg::ST_FINISH:  state_next = pdrb_pkg::ST_DONE;
      pdrb_pkg::ST_DONE: begin
        if (out_free) state_next = pdrb_pkg::ST_IDLE;
      end
      default: state_next = pdrb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = pdrb_pkg::MUL_BX;
    item_ready = 1'b0;
    case (state)
      pdrb_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.capture = item_valid;
        cmd.load = item_valid && !item_op;
      end
      pdrb_pkg::ST_BLEND_X: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_BX;
      end
      pdrb_pkg::ST_BLEND_Y: begin
        cmd.upd_x = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_BY;
      end
      pdrb_pkg::ST_DIST: begin
        cmd.upd_y = 1'b1;
        cmd.wrap_h = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_LIN;
      end
      pdrb_pkg::ST_INC: begin
        cmd.dist_en = 1'b1;
        cmd.cordic_start = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_ANG;
      end
      pdrb_pkg::ST_ROTATE: begin
        cmd.inc_en = 1'b1;
        cmd.cordic_step = 1'b1;
      end
      pdrb_pkg::ST_MOVE_X: begin
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_CX;
      end
      pdrb_pkg::ST_MOVE_Y: begin
        cmd.rnd30 = 1'b1;
        cmd.upd_x = 1'b1;
        cmd.prod_en = 1'b1;
        cmd.mul_sel = pdrb_pkg::MUL_SY;
      end
      pdrb_pkg::ST_FINISH: begin
        cmd.rnd30 = 1'b1;
        cmd.upd_y = 1'b1;
        cmd.final_h = 1'b1;
      end
      pdrb_pkg::ST_DONE: begin
        cmd.out_load = out_free;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/pdrb_dp.sv
// pdrb_dp: pose registers, shared multiplier, rotation unit and result registers
// depends on pdrb_pkg
`default_nettype none
module pdrb_dp #(
  parameter int unsigned SINCOS_ITERATIONS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire pdrb_pkg::cmd_t                            cmd,
  output pdrb_pkg::status_t                              status,
  input  wire logic signed [pdrb_pkg::POS_W-1:0]         ref_x,
  input  wire logic signed [pdrb_pkg::POS_W-1:0]         ref_y,
  input  wire logic signed [pdrb_pkg::REF_HEAD_W-1:0]    ref_heading,
  input  wire logic signed [pdrb_pkg::SPEED_W-1:0]       lin_speed,
  input  wire logic signed [pdrb_pkg::SPEED_W-1:0]       ang_speed,
  input  wire logic                                      cfg_write,
  input  wire logic [pdrb_pkg::IDX_W-1:0]                cfg_index,
  input  wire logic [pdrb_pkg::CFG_W-1:0]                cfg_data,
  output logic signed [pdrb_pkg::POS_W-1:0]              est_x_out,
  output logic signed [pdrb_pkg::POS_W-1:0]              est_y_out,
  output logic signed [pdrb_pkg::REF_HEAD_W-1:0]         est_heading_out
);

  localparam int unsigned ITERS =
    (SINCOS_ITERATIONS > pdrb_pkg::ATAN_ENTRIES) ? pdrb_pkg::ATAN_ENTRIES : SINCOS_ITERATIONS;
  localparam logic [pdrb_pkg::CNT_W-1:0] LAST = pdrb_pkg::CNT_W'(ITERS - 1);

  logic [pdrb_pkg::CFG_W-1:0] blend_gain, tick_period;
  logic signed [pdrb_pkg::POS_W-1:0] rx, ry, pos_x, pos_y;
  logic signed [pdrb_pkg::SPEED_W-1:0] lin, ang;
  logic signed [pdrb_pkg::HEAD_W-1:0] heading, inc;
  logic signed [pdrb_pkg::DIST_W-1:0] distance;
  logic signed [pdrb_pkg::PROD_W-1:0] prod;
  logic signed [pdrb_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pdrb_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pdrb_pkg::PROD_W-1:0] r16, r30, rsel;
  logic signed [pdrb_pkg::POS_W+1:0] sum_x, sum_y;
  logic signed [pdrb_pkg::HEAD_W:0] inc_full, head_sum;
  logic signed [pdrb_pkg::ANG_W-1:0] z, z_init, z_adj, atan_ext;
  logic signed [pdrb_pkg::CORD_W-1:0] cx, cy, xs, ys;
  logic flip, flip_init;
  logic [pdrb_pkg::CNT_W-1:0] cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_gain <= pdrb_pkg::BLEND_GAIN_RST;
      tick_period <= pdrb_pkg::TICK_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pdrb_pkg::REG_BLEND_GAIN:  blend_gain <= cfg_data;
        pdrb_pkg::REG_TICK_PERIOD: tick_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      pdrb_pkg::MUL_BX: begin
        mul_a = 33'(rx) - 33'(pos_x);
        mul_b = {16'd0, blend_gain};
      end
      pdrb_pkg::MUL_BY: begin
        mul_a = 33'(ry) - 33'(pos_y);
        mul_b = {16'd0, blend_gain};
      end
      pdrb_pkg::MUL_LIN: begin
        mul_a = 33'(lin);
        mul_b = {16'd0, tick_period};
      end
      pdrb_pkg::MUL_ANG: begin
        mul_a = 33'(ang);
        mul_b = {16'd0, tick_period};
      end
      pdrb_pkg::MUL_CX: begin
        mul_a = 33'(distance);
        mul_b = cx;
      end
      pdrb_pkg::MUL_SY: begin
        mul_a = 33'(distance);
        mul_b = cy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // round half up
  assign r16 = (prod + 65'sd32768) >>> 16;
  assign r30 = (prod + 65'sd536870912) >>> 30;
  assign rsel = cmd.rnd30 ? r30 : r16;
  assign sum_x = 34'(pos_x) + rsel[pdrb_pkg::POS_W+1:0];
  assign sum_y = 34'(pos_y) + rsel[pdrb_pkg::POS_W+1:0];

  // increment clamp and heading sum
  always_comb begin
    inc_full = r16[pdrb_pkg::HEAD_W:0];
    if (r16 > 65'(pdrb_pkg::PI_Q)) inc_full = pdrb_pkg::PI_Q;
    else if (r16 < -65'(pdrb_pkg::PI_Q)) inc_full = -pdrb_pkg::PI_Q;
  end
  assign head_sum = 21'(heading) + 21'(inc);

  // rotation start angle, folded into plus or minus half pi
  always_comb begin
    z_init = 34'(heading) <<< 14;
    flip_init = 1'b0;
    z_adj = z_init;
    if (z_init > pdrb_pkg::HALF_PI_Q30) begin
      z_adj = z_init - pdrb_pkg::PI_Q30;
      flip_init = 1'b1;
    end else if (z_init < -pdrb_pkg::HALF_PI_Q30) begin
      z_adj = z_init + pdrb_pkg::PI_Q30;
      flip_init = 1'b1;
    end
  end

  assign xs = cx >>> cnt;
  assign ys = cy >>> cnt;
  assign atan_ext = {4'd0, pdrb_pkg::atan_q30(cnt)};
  assign status.last_iter = (cnt == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
    end else begin
      if (cmd.load) begin
        pos_x <= ref_x;
        pos_y <= ref_y;
        heading <= 20'(ref_heading);
      end
      if (cmd.upd_x) pos_x <= pdrb_pkg::sat_pos(sum_x);
      if (cmd.upd_y) pos_y <= pdrb_pkg::sat_pos(sum_y);
      if (cmd.wrap_h) heading <= pdrb_pkg::wrap_heading(21'(heading));
      if (cmd.final_h) heading <= pdrb_pkg::wrap_heading(head_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rx <= ref_x;
      ry <= ref_y;
      lin <= lin_speed;
      ang <= ang_speed;
    end
    if (cmd.prod_en) prod <= 65'(mul_a) * 65'(mul_b);
    if (cmd.dist_en) distance <= r16[pdrb_pkg::DIST_W-1:0];
    if (cmd.inc_en) inc <= inc_full[pdrb_pkg::HEAD_W-1:0];
    if (cmd.cordic_start) begin
      z <= z_adj;
      flip <= flip_init;
      cx <= pdrb_pkg::CORDIC_START;
      cy <= '0;
      cnt <= '0;
    end else if (cmd.cordic_step) begin
      if (status.last_iter) begin
        if (z >= 0) begin
          cx <= flip ? -(cx - ys) : (cx - ys);
          cy <= flip ? -(cy + xs) : (cy + xs);
        end else begin
          cx <= flip ? -(cx + ys) : (cx + ys);
          cy <= flip ? -(cy - xs) : (cy - xs);
        end
      end else if (z >= 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
      end
      z <= (z >= 0) ? z - atan_ext : z + atan_ext;
      cnt <= cnt + 1'b1;
    end
    if (cmd.out_load) begin
      est_x_out <= pos_x;
      est_y_out <= pos_y;
      est_heading_out <= heading[pdrb_pkg::REF_HEAD_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/pose_dead_reckoning_blend.sv
// pose_dead_reckoning_blend: planar pose estimator top level
// depends on pdrb_pkg, pdrb_if, pdrb_ctrl and pdrb_dp
//
// usage:
//   item_in carries one item per transfer: op 0 loads x, y and heading from
//   the reference pose, op 1 runs one tick (blend toward the reference,
//   move along the heading, turn by the yaw increment)
//   result_out carries the estimate after every item, one transfer per item
//   cfg writes blend_gain (index 0) or tick_period (index 1); other indices
//   are ignored; cfg is always ready, write only while idle
// timing:
//   a load goes straight to DONE and shows its result when the output is loaded
//   a tick runs the blend, distance and increment states, then the rotation unit,
//   which does one step per cycle, then the move and finish states and DONE
//   next item is taken in IDLE, the cycle after the result is loaded, so the
//   block takes no new item before the last one's result is loaded
// reset: estimate cleared to zero, registers to their defaults
// stall: a result waits in the output register; the next item is accepted
//   and worked on, and is held at the end until the output frees
`default_nettype none
module pose_dead_reckoning_blend #(
  parameter int unsigned SINCOS_ITERATIONS = 16
) (
  input wire logic       clk,
  input wire logic       rst,
  pdrb_item_if.sink      item_in,
  pdrb_result_if.source  result_out,
  pdrb_cfg_if.sink       cfg
);

  pdrb_pkg::cmd_t cmd;
  pdrb_pkg::status_t status;

  assign cfg.ready = 1'b1;

  pdrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_in.valid),
    .item_op      (item_in.op),
    .item_ready   (item_in.ready),
    .result_valid (result_out.valid),
    .result_ready (result_out.ready),
    .status       (status),
    .cmd          (cmd)
  );

  pdrb_dp #(
    .SINCOS_ITERATIONS (SINCOS_ITERATIONS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .ref_x           (item_in.ref_x),
    .ref_y           (item_in.ref_y),
    .ref_heading     (item_in.ref_heading),
    .lin_speed       (item_in.lin_speed),
    .ang_speed       (item_in.ang_speed),
    .cfg_write       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .est_x_out       (result_out.est_x_out),
    .est_y_out       (result_out.est_y_out),
    .est_heading_out (result_out.est_heading_out)
  );

endmodule
`default_nettype wire
